FILE: rtl/tss_pkg.sv
`default_nettype none
package tss_pkg;

  localparam int POS_BITS = 16;
  localparam int LEN_BITS = 12;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  // Token kinds
  typedef enum logic [3:0] {
    KIND_INVALID = 4'd0,
    KIND_EOF     = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_STRING  = 4'd3,
    KIND_ANNOT   = 4'd4,
    KIND_COMMENT = 4'd5,
    KIND_DCOLON  = 4'd6,
    KIND_TDOTS   = 4'd7,
    KIND_PUNCT   = 4'd8
  } kind_t;

  // Scanner modes, one-hot
  typedef enum logic [8:0] {
    MODE_IDLE    = 9'b000000001,
    MODE_DOT1    = 9'b000000010,
    MODE_DOT2    = 9'b000000100,
    MODE_COLON   = 9'b000001000,
    MODE_SLASH   = 9'b000010000,
    MODE_COMMENT = 9'b000100000,
    MODE_ANNOT   = 9'b001000000,
    MODE_STRING  = 9'b010000000,
    MODE_IDENT   = 9'b100000000
  } mode_t;

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRC   = 8'h7B;
  localparam logic [7:0] CH_RBRC   = 8'h7D;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           punct_char;
    logic [POS_BITS-1:0]  start_pos;
    logic [LEN_BITS-1:0]  token_len;
    logic                 len_saturated;
  } token_t;

  // Tokens produced by one byte
  typedef struct packed {
    logic [1:0]       n;
    token_t [2:0]     tok;
  } step_t;

  function automatic token_t make_tok(kind_t k, logic [7:0] pc, logic [POS_BITS-1:0] st,
                                     logic [LEN_BITS-1:0] len, logic sat);
    token_t t;
    t.kind          = k;
    t.punct_char    = pc;
    t.start_pos     = st;
    t.token_len     = len;
    t.len_saturated = sat;
    return t;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LBRK) || (c == CH_RBRK) ||
           (c == CH_LBRC) || (c == CH_RBRC) || (c == CH_SEMI) || (c == CH_DOLLAR) ||
           (c == CH_EQUAL) || (c == CH_COMMA);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tss_core.sv
`default_nettype none
module tss_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire logic [7:0]    ch,
  output tss_pkg::step_t     res
);
  import tss_pkg::*;

  mode_t               mode, mode_next;
  logic [POS_BITS-1:0] tstart, tstart_next;
  logic [LEN_BITS-1:0] tcount, tcount_next;
  logic                clamped, clamped_next;
  logic [POS_BITS-1:0] byte_pos, byte_pos_next;

  // Scan of a byte with no token in progress
  token_t idle_tok;
  logic   idle_emit;
  logic   idle_begin;
  mode_t  idle_mode;

  always_comb begin
    idle_tok   = make_tok(KIND_INVALID, 8'h00, byte_pos, LEN_BITS'(1), 1'b0);
    idle_emit  = 1'b0;
    idle_begin = 1'b0;
    idle_mode  = MODE_IDLE;
    priority if (ch == CH_NUL) begin
      idle_emit     = 1'b1;
      idle_tok.kind = KIND_EOF;
    end else if (is_space(ch)) begin
      idle_emit = 1'b0;
    end else if (is_punct(ch)) begin
      idle_emit           = 1'b1;
      idle_tok.kind       = KIND_PUNCT;
      idle_tok.punct_char = ch;
    end else if (ch == CH_DOT) begin
      idle_begin = 1'b1;
      idle_mode  = MODE_DOT1;
    end else if (ch == CH_COLON) begin
      idle_begin = 1'b1;
      idle_mode  = MODE_COLON;
    end else if (ch == CH_SLASH) begin
      idle_begin = 1'b1;
      idle_mode  = MODE_SLASH;
    end else if (ch == CH_AT) begin
      idle_begin = 1'b1;
      idle_mode  = MODE_ANNOT;
    end else if (ch == CH_QUOTE) begin
      idle_begin = 1'b1;
      idle_mode  = MODE_STRING;
    end else if (is_alpha(ch)) begin
      idle_begin = 1'b1;
      idle_mode  = MODE_IDENT;
    end else begin
      idle_emit = 1'b1;
    end
  end

  // Mode transition and token list for one byte
  always_comb begin
    logic [1:0]          k;
    logic                go_idle;
    logic [LEN_BITS-1:0] cnt_b;
    logic                clp_b;
    k            = 2'd0;
    go_idle      = 1'b0;
    res          = '0;
    mode_next    = mode;
    tstart_next  = tstart;
    tcount_next  = tcount;
    clamped_next = clamped;
    // bumped count
    cnt_b = (tcount == LEN_MAX) ? tcount : tcount + 1'b1;
    clp_b = (tcount == LEN_MAX) ? 1'b1 : clamped;

    unique case (mode)
      MODE_DOT1: begin
        if (ch == CH_DOT) begin
          mode_next   = MODE_DOT2;
          tcount_next = LEN_BITS'(2);
        end else begin
          res.tok[k] = make_tok(KIND_INVALID, 8'h00, tstart, LEN_BITS'(1), 1'b0);
          k          = k + 2'd1;
          go_idle    = 1'b1;
        end
      end
      MODE_DOT2: begin
        if (ch == CH_DOT) begin
          mode_next  = MODE_IDLE;
          res.tok[k] = make_tok(KIND_TDOTS, 8'h00, tstart, LEN_BITS'(3), 1'b0);
          k          = k + 2'd1;
        end else begin
          res.tok[k] = make_tok(KIND_INVALID, 8'h00, tstart, LEN_BITS'(1), 1'b0);
          k          = k + 2'd1;
          res.tok[k] = make_tok(KIND_INVALID, 8'h00, POS_BITS'(tstart + 1'b1),
                                LEN_BITS'(1), 1'b0);
          k          = k + 2'd1;
          go_idle    = 1'b1;
        end
      end
      MODE_COLON: begin
        if (ch == CH_COLON) begin
          mode_next  = MODE_IDLE;
          res.tok[k] = make_tok(KIND_DCOLON, 8'h00, tstart, LEN_BITS'(2), 1'b0);
          k          = k + 2'd1;
        end else begin
          res.tok[k] = make_tok(KIND_INVALID, 8'h00, tstart, LEN_BITS'(1), 1'b0);
          k          = k + 2'd1;
          go_idle    = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (ch == CH_SLASH) begin
          mode_next    = MODE_COMMENT;
          tcount_next  = cnt_b;
          clamped_next = clp_b;
        end else begin
          res.tok[k] = make_tok(KIND_INVALID, 8'h00, tstart, LEN_BITS'(1), 1'b0);
          k          = k + 2'd1;
          go_idle    = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (ch == CH_LF || ch == CH_CR || ch == CH_NUL) begin
          res.tok[k] = make_tok(KIND_COMMENT, 8'h00, tstart, tcount, clamped);
          k          = k + 2'd1;
          go_idle    = 1'b1;
        end else begin
          tcount_next  = cnt_b;
          clamped_next = clp_b;
        end
      end
      MODE_ANNOT, MODE_IDENT: begin
        if (is_ident(ch)) begin
          tcount_next  = cnt_b;
          clamped_next = clp_b;
        end else begin
          // a lone at-sign is malformed
          priority if (mode == MODE_IDENT) begin
            res.tok[k] = make_tok(KIND_IDENT, 8'h00, tstart, tcount, clamped);
          end else if (tcount > LEN_BITS'(1) || clamped) begin
            res.tok[k] = make_tok(KIND_ANNOT, 8'h00, tstart, tcount, clamped);
          end else begin
            res.tok[k] = make_tok(KIND_INVALID, 8'h00, tstart, LEN_BITS'(1), 1'b0);
          end
          k       = k + 2'd1;
          go_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        priority if (ch == CH_QUOTE) begin
          tcount_next  = cnt_b;
          clamped_next = clp_b;
          mode_next    = MODE_IDLE;
          res.tok[k]   = make_tok(KIND_STRING, 8'h00, tstart, cnt_b, clp_b);
          k            = k + 2'd1;
        end else if (ch == CH_NUL) begin
          // unterminated string, then end of file
          res.tok[k] = make_tok(KIND_INVALID, 8'h00, tstart, tcount, clamped);
          k          = k + 2'd1;
          go_idle    = 1'b1;
        end else begin
          tcount_next  = cnt_b;
          clamped_next = clp_b;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    // rescan the current byte from idle
    if (go_idle) begin
      mode_next = idle_mode;
      if (idle_begin) begin
        tstart_next  = byte_pos;
        tcount_next  = LEN_BITS'(1);
        clamped_next = 1'b0;
      end
      if (idle_emit) begin
        res.tok[k] = idle_tok;
        k          = k + 2'd1;
      end
    end
    res.n = k;
  end

  // Restart position after end of file
  assign byte_pos_next = (ch == CH_NUL) ? '0 : POS_BITS'(byte_pos + 1'b1);

  // Advance scanner state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      tstart   <= '0;
      tcount   <= '0;
      clamped  <= 1'b0;
      byte_pos <= '0;
    end else if (fire) begin
      mode     <= mode_next;
      tstart   <= tstart_next;
      tcount   <= tcount_next;
      clamped  <= clamped_next;
      byte_pos <= byte_pos_next;
    end
  end

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_IDLE |-> tcount != '0)
    else $error("token count is zero inside a token");

  a_dots_count: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DOT2 |-> tcount == LEN_BITS'(2))
    else $error("double dot state with wrong count");

  a_clamp_at_max: assert property (@(posedge clk) disable iff (rst)
    clamped |-> tcount == LEN_MAX)
    else $error("clamp flag set below the count limit");

endmodule
`default_nettype wire

FILE: rtl/script_token_scanner_unit.sv
`default_nettype none
// Byte scanner: one byte per transfer in, one token per transfer out.
// A byte passes through the input register, then the token buffer, before its
// first token can transfer out.
// Throughput: one byte per cycle while each byte yields at most one token and the receiver
// does not stall; a byte's k tokens hold the three-entry token buffer until all go out.
// Synchronous reset clears the scanner mode, position and counts, and empties both stages.
module script_token_scanner_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     ch,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [3:0]                          kind,
  output logic [7:0]                          punct_char,
  output logic [tss_pkg::POS_BITS-1:0]        start_pos,
  output logic [tss_pkg::LEN_BITS-1:0]        token_len,
  output logic                                len_saturated
);
  import tss_pkg::*;

  logic          s1_valid;
  logic [7:0]    ch_q;
  logic          fire;
  logic          out_xfer;
  logic          tb_last;
  step_t         res;
  token_t [2:0]  tb;
  logic [1:0]    tb_cnt;
  logic [1:0]    tb_idx;
  token_t        cur;

  assign out_xfer = out_valid && !out_stall;
  assign tb_last  = (tb_idx == tb_cnt - 2'd1);
  // Process the held byte once the token buffer drains
  assign fire     = s1_valid && ((tb_cnt == 2'd0) || (out_xfer && tb_last));
  assign in_stall = s1_valid && !fire;

  // Input register: load on a free slot or when the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || fire) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_valid || fire) begin
      ch_q <= ch;
    end
  end

  tss_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ch   (ch_q),
    .res  (res)
  );

  // Token buffer: fill from a processed byte, drain one per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      tb_cnt <= 2'd0;
      tb_idx <= 2'd0;
    end else if (fire) begin
      tb_cnt <= res.n;
      tb_idx <= 2'd0;
    end else if (out_xfer) begin
      if (tb_last) begin
        tb_cnt <= 2'd0;
        tb_idx <= 2'd0;
      end else begin
        tb_idx <= tb_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tb <= res.tok;
    end
  end

  // Present the current token
  assign cur           = tb[tb_idx];
  assign out_valid     = (tb_cnt != 2'd0);
  assign kind          = cur.kind;
  assign punct_char    = cur.punct_char;
  assign start_pos     = cur.start_pos;
  assign token_len     = cur.token_len;
  assign len_saturated = cur.len_saturated;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    tb_cnt != 2'd0 |-> tb_idx < tb_cnt)
    else $error("token buffer index past fill");

  a_sat_at_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && len_saturated |-> token_len == LEN_MAX)
    else $error("saturated token without full length");

  a_punct_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PUNCT |-> punct_char == 8'h00)
    else $error("punctuation byte on a non-punctuation token");

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(ch_q))
    else $error("held byte lost before processing");

endmodule
`default_nettype wire

FILE: dv/tb_script_token_scanner_unit.sv
`default_nettype none
module tb_script_token_scanner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tss_pkg::*;

  // Receiver hold-off that backs the scanner up into its input
  localparam int HOLD_AT  = 60;
  localparam int HOLD_LEN = 300;
  localparam int RANDOM_ITEMS = 170;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          ch = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [3:0]          kind;
  logic [7:0]          punct_char;
  logic [POS_BITS-1:0] start_pos;
  logic [LEN_BITS-1:0] token_len;
  logic                len_saturated;

  script_token_scanner_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .punct_char    (punct_char),
    .start_pos     (start_pos),
    .token_len     (token_len),
    .len_saturated (len_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Byte classes
  // ---------------------------------------------------------------------------
  function automatic bit ws_byte(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit punct_byte(input logic [7:0] c);
    case (c)
      CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC,
      CH_SEMI, CH_DOLLAR, CH_EQUAL, CH_COMMA: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit lead_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == CH_UNDER);
  endfunction

  function automatic bit word_byte(input logic [7:0] c);
    return lead_byte(c) || (c >= "0" && c <= "9");
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  mode_t               sc_mode = MODE_IDLE;
  logic [POS_BITS-1:0] tok_start = '0;
  logic [LEN_BITS-1:0] tok_count = '0;
  logic                tok_clamped = 1'b0;
  logic [POS_BITS-1:0] scan_pos = '0;
  token_t              tok_q[$];

  task automatic expect_tok(input kind_t k, input logic [7:0] pc,
                            input logic [POS_BITS-1:0] st,
                            input logic [LEN_BITS-1:0] len, input logic sat);
    token_t t;
    t.kind          = k;
    t.punct_char    = pc;
    t.start_pos     = st;
    t.token_len     = len;
    t.len_saturated = sat;
    tok_q.push_back(t);
  endtask

  task automatic open_tok(input mode_t m, input logic [POS_BITS-1:0] p);
    sc_mode     = m;
    tok_start   = p;
    tok_count   = LEN_BITS'(1);
    tok_clamped = 1'b0;
  endtask

  // Count one more byte, clamping at the counter's top
  task automatic grow_tok();
    if (tok_count == LEN_MAX) tok_clamped = 1'b1;
    else tok_count = tok_count + 1'b1;
  endtask

  // Scan a byte with no token in progress
  task automatic scan_fresh(input logic [7:0] c, input logic [POS_BITS-1:0] p);
    sc_mode = MODE_IDLE;
    if (c == CH_NUL) expect_tok(KIND_EOF, 8'h00, p, LEN_BITS'(1), 1'b0);
    else if (ws_byte(c)) begin
    end else if (punct_byte(c)) expect_tok(KIND_PUNCT, c, p, LEN_BITS'(1), 1'b0);
    else if (c == CH_DOT) open_tok(MODE_DOT1, p);
    else if (c == CH_COLON) open_tok(MODE_COLON, p);
    else if (c == CH_SLASH) open_tok(MODE_SLASH, p);
    else if (c == CH_AT) open_tok(MODE_ANNOT, p);
    else if (c == CH_QUOTE) open_tok(MODE_STRING, p);
    else if (lead_byte(c)) open_tok(MODE_IDENT, p);
    else expect_tok(KIND_INVALID, 8'h00, p, LEN_BITS'(1), 1'b0);
  endtask

  task automatic scan_step(input logic [7:0] c);
    logic [POS_BITS-1:0] p;
    p = scan_pos;
    case (sc_mode)
      MODE_DOT1: begin
        if (c == CH_DOT) begin
          sc_mode   = MODE_DOT2;
          tok_count = LEN_BITS'(2);
        end else begin
          expect_tok(KIND_INVALID, 8'h00, tok_start, LEN_BITS'(1), 1'b0);
          scan_fresh(c, p);
        end
      end
      MODE_DOT2: begin
        if (c == CH_DOT) begin
          sc_mode = MODE_IDLE;
          expect_tok(KIND_TDOTS, 8'h00, tok_start, LEN_BITS'(3), 1'b0);
        end else begin
          expect_tok(KIND_INVALID, 8'h00, tok_start, LEN_BITS'(1), 1'b0);
          expect_tok(KIND_INVALID, 8'h00, tok_start + 1'b1, LEN_BITS'(1), 1'b0);
          scan_fresh(c, p);
        end
      end
      MODE_COLON: begin
        if (c == CH_COLON) begin
          sc_mode = MODE_IDLE;
          expect_tok(KIND_DCOLON, 8'h00, tok_start, LEN_BITS'(2), 1'b0);
        end else begin
          expect_tok(KIND_INVALID, 8'h00, tok_start, LEN_BITS'(1), 1'b0);
          scan_fresh(c, p);
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          sc_mode = MODE_COMMENT;
          grow_tok();
        end else begin
          expect_tok(KIND_INVALID, 8'h00, tok_start, LEN_BITS'(1), 1'b0);
          scan_fresh(c, p);
        end
      end
      MODE_COMMENT: begin
        if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
          expect_tok(KIND_COMMENT, 8'h00, tok_start, tok_count, tok_clamped);
          scan_fresh(c, p);
        end else begin
          grow_tok();
        end
      end
      MODE_ANNOT, MODE_IDENT: begin
        if (word_byte(c)) begin
          grow_tok();
        end else begin
          if (sc_mode == MODE_IDENT)
            expect_tok(KIND_IDENT, 8'h00, tok_start, tok_count, tok_clamped);
          else if (tok_count > LEN_BITS'(1) || tok_clamped)
            expect_tok(KIND_ANNOT, 8'h00, tok_start, tok_count, tok_clamped);
          else
            expect_tok(KIND_INVALID, 8'h00, tok_start, LEN_BITS'(1), 1'b0);
          scan_fresh(c, p);
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          grow_tok();
          sc_mode = MODE_IDLE;
          expect_tok(KIND_STRING, 8'h00, tok_start, tok_count, tok_clamped);
        end else if (c == CH_NUL) begin
          // unterminated string: flag what was seen, then end of file
          expect_tok(KIND_INVALID, 8'h00, tok_start, tok_count, tok_clamped);
          scan_fresh(c, p);
        end else begin
          grow_tok();
        end
      end
      default: scan_fresh(c, p);
    endcase
    scan_pos = (c == CH_NUL) ? '0 : p + 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus source
  // ---------------------------------------------------------------------------
  logic [7:0]          byte_q[$];
  int                  word_items = 0;

  task automatic put(input logic [7:0] c);
    byte_q.push_back(c);
    if (!ws_byte(c)) word_items++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] rand_lead();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_word();
    int r;
    r = $urandom_range(0, 12);
    if (r < 3) return 8'("0" + $urandom_range(0, 9));
    return rand_lead();
  endfunction

  // String body: anything but the quote and NUL
  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  // Comment body: anything but the line ends and NUL
  function automatic logic [7:0] rand_note();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(0, 9))
      0: return CH_LPAR;
      1: return CH_RPAR;
      2: return CH_LBRK;
      3: return CH_RBRK;
      4: return CH_LBRC;
      5: return CH_RBRC;
      6: return CH_SEMI;
      7: return CH_DOLLAR;
      8: return CH_EQUAL;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  task automatic put_word(input int n);
    put(rand_lead());
    repeat (n - 1) put(rand_word());
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      sc_mode     = MODE_IDLE;
      tok_start   = '0;
      tok_count   = '0;
      tok_clamped = 1'b0;
      scan_pos    = '0;
    end else begin
      // predict from the byte that transfers at this edge
      if (in_valid && !in_stall) scan_step(ch);
      // offer the next byte once the slot is free
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          ch       <= byte_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern, with one long hold-off
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_cycle  = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) out_stall <= 1'b1;
      else begin
        case ((rx_cycle >> 7) % 6)
          0, 1: out_stall <= 1'b0;
          2: out_stall <= ($urandom_range(0, 3) == 0);
          3: out_stall <= ($urandom_range(0, 3) != 0);
          4: out_stall <= rx_cycle[2];
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each token transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  int err_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < 40)
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    token_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tok_q.size() == 0) begin
        report_mismatch("token with none pending, kind", kind, 0);
      end else begin
        want = tok_q.pop_front();
        if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
        if (punct_char !== want.punct_char)
          report_mismatch("punct_char", punct_char, want.punct_char);
        if (start_pos !== want.start_pos)
          report_mismatch("start_pos", start_pos, want.start_pos);
        if (token_len !== want.token_len)
          report_mismatch("token_len", token_len, want.token_len);
        if (len_saturated !== want.len_saturated)
          report_mismatch("len_saturated", len_saturated, want.len_saturated);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    int n;

    // directed: every punctuation byte, multi-byte tokens, broken prefixes
    put_text("z_9([{}]);$=,");
    put_text("...");
    put_text("::");
    put_text("..@:/. ");
    put(CH_QUOTE);
    put(8'hFF);
    put(CH_NUL);
    put(8'h80);
    put_text("7");
    put(CH_NUL);

    // random token streams with some noise
    word_items = 0;
    while (word_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 23);
      case (r)
        0, 1, 2, 3: put_word($urandom_range(1, 8));
        4, 5, 6: put(rand_punct());
        7, 8: put(rand_space());
        9: put_text("...");
        10: put_text("::");
        11, 12: begin
          put_text("//");
          n = $urandom_range(0, 10);
          repeat (n) put(rand_note());
          case ($urandom_range(0, 2))
            0: put(CH_LF);
            1: put(CH_CR);
            default: put(CH_NUL);
          endcase
        end
        13, 14: begin
          put(CH_AT);
          n = $urandom_range(1, 6);
          repeat (n) put(rand_word());
        end
        15, 16: begin
          put(CH_QUOTE);
          n = $urandom_range(0, 8);
          repeat (n) put(rand_text());
          put(CH_QUOTE);
        end
        17: begin
          case ($urandom_range(0, 4))
            0: put_text(".");
            1: put_text("..");
            2: put_text(":");
            3: put_text("/");
            default: put_text("@");
          endcase
        end
        18: begin
          put(CH_QUOTE);
          n = $urandom_range(0, 4);
          repeat (n) put(rand_text());
          put(CH_NUL);
        end
        19: put(CH_NUL);
        default: put(8'($urandom_range(0, 255)));
      endcase
    end

    // broken double dot, then end of input
    put_text(".. ab;");
    put(CH_NUL);

    // release reset
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain input, then outstanding tokens, then let the pipeline settle
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (tok_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0 && tok_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
